[src/shrc_pkg.sv]
// shared types and constants of the sampled hash repeat counter
`timescale 1ns / 1ps
`default_nettype none

package shrc_pkg;

  // fixed field widths
  localparam int WordW   = 64;
  localparam int TimeW   = 32;
  localparam int ExpW    = 33;
  localparam int HashW   = 16;
  localparam int BucketW = 13;
  localparam int HitsW   = 8;
  localparam int HoldW   = 16;
  localparam int LimitW  = 8;
  localparam int RegIdxW = 8;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] RegHold      = 8'd0;
  localparam logic [RegIdxW-1:0] RegMailLimit = 8'd1;
  localparam logic [RegIdxW-1:0] RegPostLimit = 8'd2;

  // reset values of the configuration registers
  localparam logic [HoldW-1:0]  HoldReset      = 16'd1800;
  localparam logic [LimitW-1:0] MailLimitReset = 8'd3;
  localparam logic [LimitW-1:0] PostLimitReset = 8'd1;

  // table lookup request from the hashing front to the table back end
  typedef struct packed {
    logic             pool;
    logic [HashW-1:0] hash;
    logic [TimeW-1:0] now;
  } req_t;

  // live configuration as seen by the back end
  typedef struct packed {
    logic [HoldW-1:0]  hold;
    logic [LimitW-1:0] mail_limit;
    logic [LimitW-1:0] post_limit;
  } cfg_t;

  // back end status toward the top level
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

[src/shrc_ifs.sv]
// valid/ready channel interfaces of the sampled hash repeat counter
`timescale 1ns / 1ps
`default_nettype none

interface shrc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] word;
  logic        first;
  logic        last;
  logic        pool_select;
  logic [31:0] now_seconds;

  modport source (output valid, word, first, last, pool_select, now_seconds, input ready);
  modport sink (input valid, word, first, last, pool_select, now_seconds, output ready);
endinterface

interface shrc_out_if;
  logic        valid;
  logic        ready;
  logic        repeat_flag;
  logic [12:0] bucket;
  logic [7:0]  hits;

  modport source (output valid, repeat_flag, bucket, hits, input ready);
  modport sink (input valid, repeat_flag, bucket, hits, output ready);
endinterface

interface shrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/shrc_front.sv]
// hashing front: sampled xor fold behind a two-word delay line
`timescale 1ns / 1ps
`default_nettype none

module shrc_front import shrc_pkg::*; #(
  parameter int SAMPLE_STRIDE = 3
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  shrc_in_if.sink      in_i,
  input  wire logic    hold_i,
  input  wire logic    full_i,
  output logic         push_o,
  output req_t         req_o
);

  localparam int PhW = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
  localparam logic [PhW-1:0] PhLast = PhW'(SAMPLE_STRIDE - 1);

  logic [WordW-1:0] hash_q, hash_d;
  logic [WordW-1:0] dly0_q, dly0_d;
  logic [WordW-1:0] dly1_q, dly1_d;
  logic [PhW-1:0]   phase_q, phase_d;
  logic [1:0]       seen_q, seen_d;
  logic             accept;

  assign in_i.ready = !hold_i && !full_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    logic [WordW-1:0] h;
    logic [WordW-1:0] d1;
    logic [PhW-1:0]   ph;
    logic [1:0]       sn;
    h  = in_i.first ? '0 : hash_q;
    d1 = in_i.first ? '0 : dly0_q;
    ph = in_i.first ? '0 : phase_q;
    sn = in_i.first ? '0 : seen_q;
    // the oldest held word is known not to be one of the final two
    if (sn == 2'd2) begin
      if (ph == '0) begin
        h = h ^ (in_i.first ? '0 : dly1_q);
      end
      ph = (ph == PhLast) ? '0 : ph + 1'b1;
    end
    hash_d  = h;
    dly1_d  = d1;
    dly0_d  = in_i.word;
    phase_d = ph;
    seen_d  = (sn == 2'd2) ? sn : sn + 2'd1;
    push_o  = accept && in_i.last;
    req_o.pool = in_i.pool_select;
    req_o.hash = h[HashW-1:0];
    req_o.now  = in_i.now_seconds;
    // message state restarts after the last word
    if (in_i.last) begin
      hash_d  = '0;
      dly0_d  = '0;
      dly1_d  = '0;
      phase_d = '0;
      seen_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      dly0_q  <= '0;
      dly1_q  <= '0;
      phase_q <= '0;
      seen_q  <= '0;
    end else if (accept) begin
      hash_q  <= hash_d;
      dly0_q  <= dly0_d;
      dly1_q  <= dly1_d;
      phase_q <= phase_d;
      seen_q  <= seen_d;
    end
  end

endmodule

`default_nettype wire

[src/shrc_queue.sv]
// two-entry request queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module shrc_queue import shrc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire req_t req_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output req_t      req_o
);

  req_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign req_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/shrc_back.sv]
// table back end: bucket read, expiry check, hit count update, result register
`timescale 1ns / 1ps
`default_nettype none

module shrc_back import shrc_pkg::*; #(
  parameter int MAIL_BUCKETS = 8192,
  parameter int POST_BUCKETS = 256,
  parameter int HIT_BITS     = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   req_valid_i,
  input  wire req_t   req_i,
  output logic        pop_o,
  input  wire cfg_t   cfg_i,
  shrc_out_if.source  out_o,
  output back_status_t status_o
);

  localparam int MaxB = (MAIL_BUCKETS > POST_BUCKETS) ? MAIL_BUCKETS : POST_BUCKETS;
  localparam int CntW = $clog2(MaxB) + 1;
  localparam int MW   = $clog2(MAIL_BUCKETS);
  localparam int PW   = $clog2(POST_BUCKETS);
  localparam int EW   = ExpW + HIT_BITS;
  localparam int CW   = (HIT_BITS > LimitW) ? HIT_BITS : LimitW;
  localparam logic [HashW-1:0] MailMask = HashW'(MAIL_BUCKETS - 1);
  localparam logic [HashW-1:0] PostMask = HashW'(POST_BUCKETS - 1);

  logic [EW-1:0] mail_mem [MAIL_BUCKETS];
  logic [EW-1:0] post_mem [POST_BUCKETS];
  logic [EW-1:0] mail_rd_q, post_rd_q;

  logic [CntW-1:0]  clr_q;
  logic             clearing;
  logic             issue, b_fire;
  logic [HashW-1:0] a_idx;

  logic             b_valid_q;
  logic             b_pool_q;
  logic [HashW-1:0] b_idx_q;
  logic [TimeW-1:0] b_now_q;
  logic             fwd_q;
  logic [EW-1:0]    fwd_data_q;

  logic [EW-1:0]       ent, new_ent;
  logic [ExpW-1:0]     new_exp;
  logic [HIT_BITS-1:0] base, cnt;
  logic [CW-1:0]       cnt_w;
  logic                rep;
  logic                same_key;

  logic                out_valid_q;
  logic                out_rep_q;
  logic [BucketW-1:0]  out_bucket_q;
  logic [HitsW-1:0]    out_hits_q;

  logic          mail_we, post_we;
  logic [MW-1:0] mail_wa;
  logic [PW-1:0] post_wa;
  logic [EW-1:0] wdata;

  // clearing sweep after reset
  assign clearing          = (clr_q != CntW'(MaxB));
  assign status_o.clearing = clearing;

  // issue stage: read the bucket while the update stage is free or moving
  assign b_fire = b_valid_q && (!out_valid_q || out_o.ready);
  assign issue  = req_valid_i && !clearing && (!b_valid_q || b_fire);
  assign pop_o  = issue;
  assign a_idx  = req_i.hash & (req_i.pool ? PostMask : MailMask);

  always_ff @(posedge clk_i) begin
    if (issue && !req_i.pool) begin
      mail_rd_q <= mail_mem[a_idx[MW-1:0]];
    end
    if (issue && req_i.pool) begin
      post_rd_q <= post_mem[a_idx[PW-1:0]];
    end
  end

  // update stage
  always_comb begin
    if (fwd_q) begin
      ent = fwd_data_q;
    end else begin
      ent = b_pool_q ? post_rd_q : mail_rd_q;
    end
    base    = ({1'b0, b_now_q} > ent[EW-1 -: ExpW]) ? '0 : ent[HIT_BITS-1:0];
    cnt     = (base == '1) ? base : base + 1'b1;
    new_exp = {1'b0, b_now_q} + ExpW'(cfg_i.hold);
    new_ent = {new_exp, cnt};
    cnt_w   = CW'(cnt);
    rep     = cnt_w > CW'(b_pool_q ? cfg_i.post_limit : cfg_i.mail_limit);
  end

  // write-back collides with a read issued in the same cycle
  assign same_key = (req_i.pool == b_pool_q) && (a_idx == b_idx_q);

  always_comb begin
    if (clearing) begin
      mail_we = (clr_q < CntW'(MAIL_BUCKETS));
      post_we = (clr_q < CntW'(POST_BUCKETS));
      mail_wa = clr_q[MW-1:0];
      post_wa = clr_q[PW-1:0];
      wdata   = '0;
    end else begin
      mail_we = b_fire && !b_pool_q;
      post_we = b_fire && b_pool_q;
      mail_wa = b_idx_q[MW-1:0];
      post_wa = b_idx_q[PW-1:0];
      wdata   = new_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mail_we) begin
      mail_mem[mail_wa] <= wdata;
    end
    if (post_we) begin
      post_mem[post_wa] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_pool_q   <= req_i.pool;
      b_idx_q    <= a_idx;
      b_now_q    <= req_i.now;
      fwd_data_q <= new_ent;
    end
    if (b_fire) begin
      out_rep_q    <= rep;
      out_bucket_q <= b_idx_q[BucketW-1:0];
      out_hits_q   <= cnt_w[HitsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      b_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing) begin
        clr_q <= clr_q + 1'b1;
      end
      if (issue) begin
        b_valid_q <= 1'b1;
        fwd_q     <= b_fire && same_key;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.repeat_flag = out_rep_q;
  assign out_o.bucket      = out_bucket_q;
  assign out_o.hits        = out_hits_q;

endmodule

`default_nettype wire

[src/sampled_hash_repeat_counter_unit.sv]
// top level of the sampled hash repeat counter: config registers, front, queue, back
// a result beat moves from the request queue through the issue stage registers and the update
//   stage into the result register, and leaves at the first edge with output ready high
// throughput: one word beat per cycle unless the queue is full or clearing runs, and one
//   table update per cycle for back-to-back last words while output ready is high, set by
//   the single read-modify-write path on each bucket memory. reset: control state clears at once,
//   then a sweep zeroes both bucket tables with input ready low; config writes are taken
`timescale 1ns / 1ps
`default_nettype none

module sampled_hash_repeat_counter_unit import shrc_pkg::*; #(
  parameter int MAIL_BUCKETS  = 8192,
  parameter int POST_BUCKETS  = 256,
  parameter int SAMPLE_STRIDE = 3,
  parameter int HIT_BITS      = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  shrc_in_if.sink    in_i,
  shrc_out_if.source out_o,
  shrc_cfg_if.sink   cfg_i
);

  cfg_t         cfg_q;
  back_status_t back_st;
  req_t         front_req, queue_req;
  logic         push, full, queue_valid, pop;

  // configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold       <= HoldReset;
      cfg_q.mail_limit <= MailLimitReset;
      cfg_q.post_limit <= PostLimitReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegHold:      cfg_q.hold       <= cfg_i.data;
        RegMailLimit: cfg_q.mail_limit <= cfg_i.data[LimitW-1:0];
        RegPostLimit: cfg_q.post_limit <= cfg_i.data[LimitW-1:0];
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  // front folds sampled words and emits one request per message
  shrc_front #(
    .SAMPLE_STRIDE(SAMPLE_STRIDE)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .hold_i (back_st.clearing),
    .full_i (full),
    .push_o (push),
    .req_o  (front_req)
  );

  // short queue decouples hashing from table updates
  shrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .req_o   (queue_req)
  );

  // back end does the bucket read-modify-write and holds the result beat
  shrc_back #(
    .MAIL_BUCKETS(MAIL_BUCKETS),
    .POST_BUCKETS(POST_BUCKETS),
    .HIT_BITS    (HIT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (queue_valid),
    .req_i       (queue_req),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .out_o       (out_o),
    .status_o    (back_st)
  );

endmodule

`default_nettype wire
